// ===== hw/rtl/lcs_length_engine_macros.svh =====
// assertion macros for the lcs length engine
// used by the top level only, expects clk and rst_n in scope
`ifndef LCS_LENGTH_ENGINE_MACROS_SVH
`define LCS_LENGTH_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lcs_pkg.sv =====
// shared types and constants for the lcs length engine
// no dependencies
package lcs_pkg;

  localparam int MAX_LEN     = 64;
  localparam int SYMBOL_BITS = 8;

  // field widths of the words
  localparam int SYM_W   = 8;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int SCORE_W = 7;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  typedef struct packed {
    logic             command;
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } in_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] lcs_length;
    logic               first_overflow;
  } out_word_t;

  // word travelling along the cell chain
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [SYM_W-1:0]   sym;
    logic [SCORE_W-1:0] left;
    logic [SCORE_W-1:0] diag;
  } lcs_wave_t;

endpackage

// ===== hw/rtl/lcs_cell.sv =====
// one cell of the dp chain: holds one first-string symbol and its row score
// depends on lcs_pkg
module lcs_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ld_en,
  input  logic [lcs_pkg::SYM_W-1:0] ld_sym,
  input  lcs_pkg::lcs_wave_t       wave_i,
  output lcs_pkg::lcs_wave_t       wave_o
);
  import lcs_pkg::*;

  logic [SYM_W-1:0]   sym_r;
  logic               active_r, active_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic               valid_r;
  lcs_wave_t          wave_r, wave_nxt;
  logic               match;
  logic [SCORE_W-1:0] val;

  // dp update for the word passing through
  always_comb begin
    match      = (sym_r[SYMBOL_BITS-1:0] == wave_i.sym[SYMBOL_BITS-1:0]);
    val        = match ? (wave_i.diag + SCORE_W'(1))
                       : ((wave_i.left > score_r) ? wave_i.left : score_r);
    score_nxt  = score_r;
    active_nxt = active_r;
    wave_nxt   = wave_i;
    if (wave_i.valid && active_r) begin
      wave_nxt.left = val;
      wave_nxt.diag = score_r;
      score_nxt     = wave_i.last ? '0 : val;
    end
    // an unloaded cell hands the left score straight on
    if (wave_i.valid && wave_i.last) begin
      active_nxt = 1'b0;
    end
    if (ld_en) begin
      active_nxt = 1'b1;
    end
  end

  // stored symbol and wave payload, no reset needed
  always_ff @(posedge clk) begin
    if (ld_en) begin
      sym_r <= ld_sym;
    end
    wave_r <= wave_nxt;
  end

  // cell control state and score
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      score_r  <= '0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      score_r  <= score_nxt;
      valid_r  <= wave_nxt.valid;
    end
  end

  always_comb begin
    wave_o       = wave_r;
    wave_o.valid = valid_r;
  end

endmodule

// ===== hw/rtl/lcs_length_engine.sv =====
// lcs length engine: the last second-string word travels the full cell chain, one cell per cycle,
// and its result is registered into the result slot at the end of the chain
// throughput: one word per cycle while loading and while streaming the second string
// after a last second-string word, in_ready stays low until the result word is taken
// reset (synchronous, rst_n low) clears lengths, flags, cell scores and valid bits
// depends on lcs_pkg, lcs_cell and lcs_length_engine_macros.svh
`include "lcs_length_engine_macros.svh"

module lcs_length_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcs_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lcs_pkg::out_word_t out_data
);
  import lcs_pkg::*;

  logic               busy_r, busy_nxt;
  logic [LEN_W-1:0]   first_length_r, first_length_nxt;
  logic               first_closed_r, first_closed_nxt;
  logic               overflow_r, overflow_nxt;
  logic               res_ovf_r, res_ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;
  logic               acc;
  logic               load_ok;
  logic [MAX_LEN-1:0] ld_vec;
  lcs_wave_t          wave [MAX_LEN+1];
  logic               end_hit;
  logic               job_end;
  logic               store_open;

  assign in_ready  = !busy_r;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // load decode, one cell per first-string word
  assign load_ok = acc && (in_data.command == CMD_LOAD) && !first_closed_r
                   && (first_length_r < LEN_W'(MAX_LEN));
  assign ld_vec  = load_ok ? (MAX_LEN'(1) << first_length_r[IDX_W-1:0]) : '0;

  // word entering the chain
  always_comb begin
    wave[0].valid = acc && (in_data.command == CMD_COMPARE);
    wave[0].last  = in_data.last_symbol;
    wave[0].sym   = in_data.symbol;
    wave[0].left  = '0;
    wave[0].diag  = '0;
  end

  // the cell chain
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    lcs_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ld_en  (ld_vec[j]),
      .ld_sym (in_data.symbol),
      .wave_i (wave[j]),
      .wave_o (wave[j+1])
    );
  end

  assign end_hit = wave[MAX_LEN].valid && wave[MAX_LEN].last;

  // string bookkeeping and result slot
  always_comb begin
    first_length_nxt = first_length_r;
    first_closed_nxt = first_closed_r;
    overflow_nxt     = overflow_r;
    res_ovf_nxt      = res_ovf_r;
    busy_nxt         = busy_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    if (acc) begin
      unique case (in_data.command)
        CMD_LOAD: begin
          if (!first_closed_r) begin
            if (first_length_r < LEN_W'(MAX_LEN)) begin
              first_length_nxt = first_length_r + LEN_W'(1);
            end else begin
              overflow_nxt = 1'b1;
            end
            if (in_data.last_symbol) begin
              first_closed_nxt = 1'b1;
            end
          end
        end
        CMD_COMPARE: begin
          first_closed_nxt = 1'b1;
          if (in_data.last_symbol) begin
            res_ovf_nxt      = overflow_r;
            first_length_nxt = '0;
            first_closed_nxt = 1'b0;
            overflow_nxt     = 1'b0;
            busy_nxt         = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (end_hit) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.lcs_length     = wave[MAX_LEN].left;
      out_data_nxt.first_overflow = res_ovf_r;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
      busy_nxt      = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    res_ovf_r  <= res_ovf_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      first_length_r <= '0;
      first_closed_r <= 1'b0;
      overflow_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      busy_r         <= busy_nxt;
      first_length_r <= first_length_nxt;
      first_closed_r <= first_closed_nxt;
      overflow_r     <= overflow_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // last second-string word taken, and store empty and open for loading
  assign job_end    = wave[0].valid && wave[0].last;
  assign store_open = (first_length_r == '0) && !first_closed_r;

  // checks
  `LCS_ASSERT_NOW(a_out_needs_job, out_valid_r, busy_r, "result word without pending job")
  `LCS_ASSERT_NOW(a_slot_free, end_hit, !out_valid_r && busy_r, "result arrived at full slot")
  `LCS_ASSERT_NOW(a_load_onehot, 1'b1, $onehot0(ld_vec), "more than one cell loaded")
  `LCS_ASSERT_NEXT(a_job_reopen, job_end, store_open && busy_r, "loading not reopened after job")

endmodule

// ===== verif/lcs_length_engine_tb.sv =====
// self-checking testbench for lcs_length_engine: drives load and compare words,
// predicts each subsequence length in a scoreboard class and checks every result word
// depends on lcs_pkg and the lcs_length_engine rtl
module lcs_length_engine_tb;
  import lcs_pkg::*;

  localparam int WORD_TARGET = 1050;
  localparam int STALL_LIMIT = 2000;
  localparam int QUIET_FROM  = 400;
  localparam int QUIET_TO    = 650;

  // length predictor and store of expected result words
  class lcs_length_board;
    logic [SYM_W-1:0]   first_syms[MAX_LEN];
    logic [LEN_W-1:0]   first_len;
    logic               first_shut;
    logic               truncated;
    logic [SCORE_W-1:0] row[MAX_LEN];
    out_word_t          pending_lengths[$];
    int                 mismatches;

    function new();
      mismatches = 0;
      clear_strings();
    endfunction

    function void clear_strings();
      first_len  = '0;
      first_shut = 1'b0;
      truncated  = 1'b0;
      foreach (row[j]) row[j] = '0;
    endfunction

    task log_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    // note an accepted input word and update the predicted row
    function void absorb_word(in_word_t w);
      logic [SCORE_W-1:0] diag;
      logic [SCORE_W-1:0] left;
      logic [SCORE_W-1:0] above;
      logic [SCORE_W-1:0] val;
      out_word_t          want;
      if (w.command == CMD_LOAD) begin
        // loads after the first string is closed change nothing
        if (first_shut) return;
        if (first_len < MAX_LEN) begin
          first_syms[first_len] = w.symbol;
          first_len++;
        end else begin
          truncated = 1'b1;
        end
        if (w.last_symbol) first_shut = 1'b1;
        return;
      end
      // a compare word closes the first string implicitly
      first_shut = 1'b1;
      diag = '0;
      left = '0;
      for (int j = 0; j < first_len; j++) begin
        above = row[j];
        if (first_syms[j] == w.symbol) val = diag + 1'b1;
        else val = (left > above) ? left : above;
        diag   = above;
        row[j] = val;
        left   = val;
      end
      if (!w.last_symbol) return;
      want.lcs_length     = (first_len != 0) ? row[first_len - 1] : '0;
      want.first_overflow = truncated;
      pending_lengths.push_back(want);
      clear_strings();
    endfunction

    // compare one accepted result word with the oldest expectation
    task check_length(out_word_t got);
      out_word_t want;
      if (pending_lengths.size() == 0) begin
        log_mismatch($sformatf("unexpected result, lcs_length %0d overflow %0b",
                               got.lcs_length, got.first_overflow));
        return;
      end
      want = pending_lengths.pop_front();
      if (got.lcs_length !== want.lcs_length)
        log_mismatch($sformatf("lcs_length got %0d want %0d",
                               got.lcs_length, want.lcs_length));
      if (got.first_overflow !== want.first_overflow)
        log_mismatch($sformatf("first_overflow got %0b want %0b",
                               got.first_overflow, want.first_overflow));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  lcs_length_board  board = new();
  logic [SYM_W-1:0] palette[4];
  int               words_sent   = 0;
  int               stall_cycles = 0;
  logic             quiet        = 1'b0;

  lcs_length_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // random back-pressure on the result side, none in the quiet stretch
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 11);
  end

  // result check and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_length(out_data);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("lcs_length_engine_tb: done, errors");
      $finish;
    end
  end

  // hold one word on the input until it is taken, with random gaps before it
  task automatic push_word(input logic cmd, input logic [SYM_W-1:0] sym, input logic last);
    in_word_t w;
    w.command     = cmd;
    w.symbol      = sym;
    w.last_symbol = last;
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    board.absorb_word(w);
    @(negedge clk);
  endtask

  // mostly a small alphabet so that matches are common
  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(99) < 80) return palette[$urandom_range(3)];
    return SYM_W'($urandom_range(255));
  endfunction

  // one first string, optional ignored loads, then one second string
  task automatic run_pair(input int flen, input int slen, input bit shut, input bit noise);
    foreach (palette[k]) palette[k] = SYM_W'($urandom_range(255));
    for (int i = 0; i < flen; i++) begin
      push_word(CMD_LOAD, pick_symbol(), shut && (i == flen - 1));
      words_sent++;
      quiet = (words_sent >= QUIET_FROM) && (words_sent < QUIET_TO);
    end
    if (noise && shut && flen > 0)
      repeat ($urandom_range(3, 1)) push_word(CMD_LOAD, pick_symbol(), 1'($urandom_range(1)));
    for (int i = 0; i < slen; i++) begin
      push_word(CMD_COMPARE, pick_symbol(), i == slen - 1);
      words_sent++;
      quiet = (words_sent >= QUIET_FROM) && (words_sent < QUIET_TO);
    end
  endtask

  initial begin
    int  roll;
    int  flen;
    int  slen;
    bit  opening;
    opening = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty first string: compare straight after reset
    push_word(CMD_COMPARE, 8'hA5, 1'b1);
    // opposite extremes, one match
    push_word(CMD_LOAD, 8'h00, 1'b0);
    push_word(CMD_LOAD, 8'hFF, 1'b1);
    push_word(CMD_COMPARE, 8'hFF, 1'b0);
    push_word(CMD_COMPARE, 8'h00, 1'b1);
    // loads after close are dropped
    push_word(CMD_LOAD, 8'h80, 1'b0);
    push_word(CMD_LOAD, 8'h01, 1'b1);
    push_word(CMD_LOAD, 8'h01, 1'b1);
    push_word(CMD_LOAD, 8'h7F, 1'b0);
    push_word(CMD_COMPARE, 8'h80, 1'b0);
    push_word(CMD_COMPARE, 8'h01, 1'b1);
    // compare while the first string is still open
    push_word(CMD_LOAD, 8'h55, 1'b0);
    push_word(CMD_LOAD, 8'hAA, 1'b0);
    push_word(CMD_COMPARE, 8'hAA, 1'b0);
    push_word(CMD_COMPARE, 8'h55, 1'b1);
    // identical strings
    push_word(CMD_LOAD, 8'h7F, 1'b0);
    push_word(CMD_LOAD, 8'hFE, 1'b1);
    push_word(CMD_COMPARE, 8'h7F, 1'b0);
    push_word(CMD_COMPARE, 8'hFE, 1'b1);

    // random string pairs, the first one overfills the store
    while (words_sent < WORD_TARGET) begin
      roll = $urandom_range(99);
      if (opening) flen = MAX_LEN + 2;
      else if (roll < 8) flen = 0;
      else if (roll < 70) flen = $urandom_range(8, 1);
      else if (roll < 90) flen = $urandom_range(MAX_LEN, 9);
      else flen = $urandom_range(MAX_LEN + 8, MAX_LEN + 1);
      slen = ($urandom_range(99) < 90) ? $urandom_range(8, 1) : $urandom_range(24, 9);
      run_pair(flen, slen, $urandom_range(99) >= 15, $urandom_range(99) < 20);
      opening = 1'b0;
    end

    // drain, then allow the pipeline latency to expose stray words
    in_valid <= 1'b0;
    while (board.pending_lengths.size() != 0) @(posedge clk);
    repeat (MAX_LEN + 8) @(posedge clk);
    if (board.mismatches == 0) $display("lcs_length_engine_tb: done, clean");
    else $display("lcs_length_engine_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_cell.sv
hw/rtl/lcs_length_engine.sv
verif/lcs_length_engine_tb.sv
